// ===== rtl/core/ahp_pkg.sv =====
// Shared constants and control types for the adaptive peak heart-rate block.
// No dependencies; used by ahp_ring, the top level and the checker under rtl/core.
`timescale 1ns / 1ps

package ahp_pkg;

    // default build parameters
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int RING_DEPTH_DEF  = 8;

    // fixed field widths
    localparam int TS_W    = 40;
    localparam int BPM_W   = 16;
    localparam int THR_W   = 23;
    localparam int RR_W    = 11;
    localparam int CFG_W   = 16;
    localparam int REFR_W  = 26;   // (65535 + 1) * 1000 fits
    localparam int RR_US_W = 21;   // microsecond span of the longest interval

    // averaging filter, all Q8, rounded half up over a divide by 100
    localparam int PAVG_OLD = 85;
    localparam int PAVG_NEW = 15;
    localparam int NAVG_OLD = 92;
    localparam int NAVG_NEW = 8;
    localparam int AVG_DIV  = 100;
    localparam int AVG_RND  = 50;

    localparam int PAVG_RST = 7680;
    localparam int NAVG_RST = 1280;
    localparam int THR_RST  = 7680;
    localparam int MIN_THR  = 1280;
    localparam int MIN_AVG_W = 13;  // holds the reset averages

    // acceptance test: peak * 10 > threshold * 7
    localparam int PK_MUL  = 10;
    localparam int THR_MUL = 7;

    localparam int REFR_RST  = 250;
    localparam int MS_DIV    = 1000;
    localparam int RR_MAX    = 1500;
    localparam int RR_MIN_US = 334000;
    localparam int RR_MAX_US = 1500999;
    localparam int BPM_NUM   = 15360000;  // 60000 * 256

    typedef struct packed {
        logic wr_en;
        logic sum_start;
    } t_ring_ctl;

endpackage

// ===== rtl/core/ahp_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module ahp_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_diff;

    // dividend bits leave r_q at the top while quotient bits enter at the bottom
    assign w_sh   = {r_rem, r_q[NUM_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[DEN_W]) begin
                    r_rem <= w_diff[DEN_W-1:0];
                    r_q   <= {r_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[DEN_W-1:0];
                    r_q   <= {r_q[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/ahp_ring.sv =====
// Beat-interval ring memory with a sequential summing pass.
// Depends on ahp_pkg for the control struct and the interval width.
`timescale 1ns / 1ps

module ahp_ring #(
    parameter int DEPTH  = 8,
    parameter int AW     = 3,
    parameter int FILL_W = 4,
    parameter int SUM_W  = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ahp_pkg::t_ring_ctl          i_ctl,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [ahp_pkg::RR_W-1:0]    i_wr_data,
    input  logic [FILL_W-1:0]           i_fill,
    output logic                        o_done,
    output logic [SUM_W-1:0]            o_sum
);

    logic [ahp_pkg::RR_W-1:0] r_mem [DEPTH];
    logic [ahp_pkg::RR_W-1:0] r_rd_data;
    logic                     r_rd_vld;
    logic                     r_active;
    logic                     r_done;
    logic [FILL_W-1:0]        r_idx;
    logic [FILL_W-1:0]        r_cnt;
    logic [SUM_W-1:0]         r_acc;

    logic                     w_rd_en;

    assign w_rd_en = r_active && (r_idx < r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // entries 0 .. fill-1 are always written before they are summed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.sum_start) begin
                r_active <= 1'b1;
                r_idx    <= '0;
                r_cnt    <= i_fill;
                r_acc    <= '0;
                r_rd_vld <= 1'b0;
            end else if (r_active) begin
                r_rd_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_idx <= r_idx + FILL_W'(1);
                end
                if (r_rd_vld) begin
                    r_acc <= r_acc + SUM_W'(r_rd_data);
                end
                if ((r_idx == r_cnt) && !r_rd_vld) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

// ===== rtl/core/adaptive_peak_heart_rate_top.sv =====
// Adaptive-threshold peak detector and heart-rate estimator, top level.
// Depends on ahp_pkg, ahp_div and ahp_ring.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: sample, timestamp_us
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: bpm .. last_interval_ms;
//                                                 tuser: bpm_valid, peak_accepted
//  cfg       in   i_cfg_we                        i_cfg_wdata: min peak spacing, ms
//
// One transaction at a time. No peak: no divider pass. Rejected peak: one pass through
// the shared divider for the noise average (NUM_W = 30 at default size). Accepted peak:
// up to three passes through the shared divider (average, interval, BPM) plus a ring sum.
// Reset is synchronous; the ring has no clearing pass. A result waiting on
// o_m_axis_tready does not block the next input; it only holds the final step.
`timescale 1ns / 1ps

module adaptive_peak_heart_rate_top #(
    parameter int SAMPLE_BITS = ahp_pkg::SAMPLE_BITS_DEF,
    parameter int RING_DEPTH  = ahp_pkg::RING_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, then [+39:] timestamp_us, zero padded
    input  logic [((SAMPLE_BITS+ahp_pkg::TS_W+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // bpm, threshold, peak_value, interval_count, last_interval_ms, zero padded
    output logic [((ahp_pkg::BPM_W+2*ahp_pkg::THR_W+$clog2(RING_DEPTH+1)
                    +ahp_pkg::RR_W+7)/8)*8-1:0] o_m_axis_tdata,
    // [0] bpm_valid, [1] peak_accepted
    output logic [1:0]           o_m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [ahp_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int AVG_W  = (MAG_W > ahp_pkg::MIN_AVG_W) ? MAG_W : ahp_pkg::MIN_AVG_W;
    localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = $clog2(RING_DEPTH * ahp_pkg::RR_MAX + 1);
    localparam int NUM_AVG_W = AVG_W + 7;
    localparam int NUM_BPM_W = $clog2(ahp_pkg::BPM_NUM * RING_DEPTH
                                      + RING_DEPTH * ahp_pkg::RR_MAX / 2 + 1);
    localparam int NUM_W0 = (NUM_AVG_W > NUM_BPM_W) ? NUM_AVG_W : NUM_BPM_W;
    localparam int NUM_W  = (NUM_W0 > ahp_pkg::RR_US_W) ? NUM_W0 : ahp_pkg::RR_US_W;
    localparam int DEN_W  = (SUM_W > 10) ? SUM_W : 10;
    localparam int OUT_W  = ((ahp_pkg::BPM_W + 2*ahp_pkg::THR_W + FILL_W
                              + ahp_pkg::RR_W + 7) / 8) * 8;
    localparam int TS_W   = ahp_pkg::TS_W;
    localparam int CMP_W  = AVG_W + 4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVAL, ST_AVG_WAIT, ST_RR_CHK, ST_RR_WAIT,
        ST_SUM_CHK, ST_SUM_WAIT, ST_BPM_WAIT, ST_THR, ST_OUT
    } t_state;

    t_state                   r_state;

    // detector state
    logic [MAG_W-1:0]         r_prev_mag;
    logic                     r_rising;
    logic [TS_W-1:0]          r_last_pt;
    logic [TS_W-1:0]          r_prev_pt;
    logic [MAG_W-1:0]         r_last_pk;
    logic [AVG_W-1:0]         r_pavg;
    logic [AVG_W-1:0]         r_navg;
    logic [AVG_W-1:0]         r_thr;
    logic [AW-1:0]            r_wpos;
    logic [FILL_W-1:0]        r_fill;
    logic [ahp_pkg::RR_W-1:0] r_last_rr;
    logic [ahp_pkg::REFR_W-1:0] r_refr_lim;

    // per-transaction working registers
    logic [MAG_W-1:0]         r_mag;
    logic [TS_W-1:0]          r_now;
    logic                     r_acc;
    logic                     r_bpm_vld;
    logic [ahp_pkg::BPM_W-1:0] r_bpm;

    logic                     r_div_start;
    logic [NUM_W-1:0]         r_div_num;
    logic [DEN_W-1:0]         r_div_den;
    ahp_pkg::t_ring_ctl       r_ring_ctl;
    logic [AW-1:0]            r_ring_waddr;
    logic [ahp_pkg::RR_W-1:0] r_ring_wdata;

    logic                     r_o_valid;
    logic [OUT_W-1:0]         r_o_tdata;
    logic [1:0]               r_o_tuser;

    logic                     w_div_done;
    logic [NUM_W-1:0]         w_quot;
    logic                     w_ring_done;
    logic [SUM_W-1:0]         w_sum;

    logic                     w_in_acc;
    logic [SAMPLE_BITS-1:0]   w_sample;
    logic [SAMPLE_BITS-1:0]   w_neg;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_rise;
    logic                     w_fall;
    logic [TS_W-1:0]          w_tdiff;
    logic                     w_time_ok;
    logic                     w_pk_ok;
    logic [NUM_W-1:0]         w_pnum;
    logic [NUM_W-1:0]         w_nnum;
    logic [TS_W-1:0]          w_rdiff;
    logic                     w_rr_ok;
    logic [AVG_W:0]           w_thr_sum;
    logic [AVG_W-1:0]         w_thr_half;
    logic [NUM_W-1:0]         w_bnum;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // magnitude with saturation of the most negative code
    assign w_sample = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_neg    = -w_sample;
    always_comb begin
        if (w_sample[SAMPLE_BITS-1]) begin
            w_mag = w_neg[SAMPLE_BITS-1] ? {MAG_W{1'b1}} : w_neg[MAG_W-1:0];
        end else begin
            w_mag = w_sample[MAG_W-1:0];
        end
    end

    assign w_rise    = r_mag > r_prev_mag;
    assign w_fall    = r_rising && (r_mag < r_prev_mag);
    assign w_tdiff   = r_now - r_last_pt;
    assign w_time_ok = (r_now >= r_last_pt) && (w_tdiff >= TS_W'(r_refr_lim));
    assign w_pk_ok   = (CMP_W'(r_prev_mag) * CMP_W'(ahp_pkg::PK_MUL))
                     > (CMP_W'(r_thr) * CMP_W'(ahp_pkg::THR_MUL));

    assign w_pnum = NUM_W'(r_pavg) * NUM_W'(ahp_pkg::PAVG_OLD)
                  + NUM_W'(r_prev_mag) * NUM_W'(ahp_pkg::PAVG_NEW)
                  + NUM_W'(ahp_pkg::AVG_RND);
    assign w_nnum = NUM_W'(r_navg) * NUM_W'(ahp_pkg::NAVG_OLD)
                  + NUM_W'(r_prev_mag) * NUM_W'(ahp_pkg::NAVG_NEW)
                  + NUM_W'(ahp_pkg::AVG_RND);

    // interval in range exactly when the microsecond span is in range
    assign w_rdiff = r_now - r_prev_pt;
    assign w_rr_ok = (r_prev_pt != '0) && (r_now >= r_prev_pt)
                   && (w_rdiff >= TS_W'(ahp_pkg::RR_MIN_US))
                   && (w_rdiff <= TS_W'(ahp_pkg::RR_MAX_US));

    assign w_thr_sum  = {1'b0, r_pavg} + {1'b0, r_navg} + (AVG_W+1)'(1);
    assign w_thr_half = w_thr_sum[AVG_W:1];

    assign w_bnum = NUM_W'(ahp_pkg::BPM_NUM) * NUM_W'(r_fill) + NUM_W'(w_sum >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refr_lim <= ahp_pkg::REFR_W'((ahp_pkg::REFR_RST + 1) * ahp_pkg::MS_DIV);
        end else if (i_cfg_we && (i_cfg_wdata != '0)) begin
            // stored as the smallest microsecond gap that passes the test
            r_refr_lim <= ahp_pkg::REFR_W'(({1'b0, i_cfg_wdata} + 17'd1)
                                           * ahp_pkg::REFR_W'(ahp_pkg::MS_DIV));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_mag  <= '0;
            r_rising    <= 1'b0;
            r_last_pt   <= '0;
            r_prev_pt   <= '0;
            r_last_pk   <= '0;
            r_pavg      <= AVG_W'(ahp_pkg::PAVG_RST);
            r_navg      <= AVG_W'(ahp_pkg::NAVG_RST);
            r_thr       <= AVG_W'(ahp_pkg::THR_RST);
            r_wpos      <= '0;
            r_fill      <= '0;
            r_last_rr   <= '0;
            r_div_start <= 1'b0;
            r_ring_ctl  <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_ring_ctl  <= '0;
            if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_mag   <= w_mag;
                        r_now   <= i_s_axis_tdata[SAMPLE_BITS +: TS_W];
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_acc      <= 1'b0;
                    r_bpm_vld  <= 1'b0;
                    r_bpm      <= '0;
                    r_prev_mag <= r_mag;
                    r_state    <= ST_THR;
                    if (w_rise) begin
                        r_rising <= 1'b1;
                    end else if (w_fall) begin
                        r_rising    <= 1'b0;
                        r_div_start <= 1'b1;
                        r_div_den   <= DEN_W'(ahp_pkg::AVG_DIV);
                        r_state     <= ST_AVG_WAIT;
                        if (w_pk_ok && w_time_ok) begin
                            r_acc     <= 1'b1;
                            r_prev_pt <= r_last_pt;
                            r_last_pt <= r_now;
                            r_last_pk <= r_prev_mag;
                            r_div_num <= w_pnum;
                        end else begin
                            r_div_num <= w_nnum;
                        end
                    end
                end
                ST_AVG_WAIT: begin
                    if (w_div_done) begin
                        if (r_acc) begin
                            r_pavg  <= AVG_W'(w_quot);
                            r_state <= ST_RR_CHK;
                        end else begin
                            r_navg  <= AVG_W'(w_quot);
                            r_state <= ST_THR;
                        end
                    end
                end
                ST_RR_CHK: begin
                    if (w_rr_ok) begin
                        r_div_start <= 1'b1;
                        r_div_num   <= NUM_W'(w_rdiff);
                        r_div_den   <= DEN_W'(ahp_pkg::MS_DIV);
                        r_state     <= ST_RR_WAIT;
                    end else begin
                        r_state <= ST_SUM_CHK;
                    end
                end
                ST_RR_WAIT: begin
                    if (w_div_done) begin
                        r_last_rr        <= w_quot[ahp_pkg::RR_W-1:0];
                        r_ring_wdata     <= w_quot[ahp_pkg::RR_W-1:0];
                        r_ring_waddr     <= r_wpos;
                        r_ring_ctl.wr_en <= 1'b1;
                        r_wpos <= (r_wpos == AW'(RING_DEPTH - 1)) ? '0 : r_wpos + AW'(1);
                        if (r_fill != FILL_W'(RING_DEPTH)) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end
                        r_state <= ST_SUM_CHK;
                    end
                end
                ST_SUM_CHK: begin
                    if (r_fill >= FILL_W'(2)) begin
                        r_ring_ctl.sum_start <= 1'b1;
                        r_state              <= ST_SUM_WAIT;
                    end else begin
                        r_state <= ST_THR;
                    end
                end
                ST_SUM_WAIT: begin
                    if (w_ring_done) begin
                        r_div_start <= 1'b1;
                        r_div_num   <= w_bnum;
                        r_div_den   <= DEN_W'(w_sum);
                        r_state     <= ST_BPM_WAIT;
                    end
                end
                ST_BPM_WAIT: begin
                    if (w_div_done) begin
                        r_bpm     <= w_quot[ahp_pkg::BPM_W-1:0];
                        r_bpm_vld <= 1'b1;
                        r_state   <= ST_THR;
                    end
                end
                ST_THR: begin
                    r_thr <= (w_thr_half < AVG_W'(ahp_pkg::MIN_THR))
                           ? AVG_W'(ahp_pkg::MIN_THR) : w_thr_half;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_o_valid || i_m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_tuser <= {r_acc, r_bpm_vld};
                        r_o_tdata <= OUT_W'({r_last_rr, r_fill,
                                             ahp_pkg::THR_W'(r_last_pk),
                                             ahp_pkg::THR_W'(r_thr), r_bpm});
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    ahp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    ahp_ring #(
        .DEPTH  (RING_DEPTH),
        .AW     (AW),
        .FILL_W (FILL_W),
        .SUM_W  (SUM_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_ring_ctl),
        .i_wr_addr (r_ring_waddr),
        .i_wr_data (r_ring_wdata),
        .i_fill    (r_fill),
        .o_done    (w_ring_done),
        .o_sum     (w_sum)
    );

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_tdata;
    assign o_m_axis_tuser  = r_o_tuser;

endmodule

// ===== rtl/core/ahp_checker.sv =====
// Port-level assertions for the heart-rate block, bound to its top level.
// Depends on ahp_pkg for field widths.
`timescale 1ns / 1ps

module ahp_checker #(
    parameter int SAMPLE_BITS = ahp_pkg::SAMPLE_BITS_DEF,
    parameter int RING_DEPTH  = ahp_pkg::RING_DEPTH_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic i_s_tready,
    input logic i_m_tvalid,
    input logic i_m_tready,
    input logic [((ahp_pkg::BPM_W+2*ahp_pkg::THR_W+$clog2(RING_DEPTH+1)
                   +ahp_pkg::RR_W+7)/8)*8-1:0] i_m_tdata,
    input logic [1:0] i_m_tuser
);

    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int FILL_LO = ahp_pkg::BPM_W + 2 * ahp_pkg::THR_W;

    // one transaction in flight: the input closes right after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input ready while a transaction is in progress");

    a_bpm_needs_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser[0]) |-> i_m_tuser[1])
        else $error("bpm reported without an accepted peak");

    a_bpm_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser[0])
            |-> (i_m_tdata[FILL_LO +: FILL_W] >= FILL_W'(2)))
        else $error("bpm reported with fewer than two intervals");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready)
            |=> (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind adaptive_peak_heart_rate_top ahp_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .RING_DEPTH  (RING_DEPTH)
) u_ahp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

// ===== test/testbench.sv =====
// Self-checking bench for adaptive_peak_heart_rate_top: drives sample/timestamp streams,
// predicts every result with an internal beat tracker and compares field by field.
// Depends on ahp_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;

    localparam int SMP_W   = ahp_pkg::SAMPLE_BITS_DEF;
    localparam int RING_N  = ahp_pkg::RING_DEPTH_DEF;
    localparam int TS_W    = ahp_pkg::TS_W;
    localparam int BPM_W   = ahp_pkg::BPM_W;
    localparam int THR_W   = ahp_pkg::THR_W;
    localparam int RR_W    = ahp_pkg::RR_W;
    localparam int CNT_W   = $clog2(RING_N + 1);
    localparam int IN_W    = ((SMP_W + TS_W + 7) / 8) * 8;
    localparam int OUT_W   = ((BPM_W + 2 * THR_W + CNT_W + RR_W + 7) / 8) * 8;
    localparam int THR_LSB = BPM_W;
    localparam int PK_LSB  = THR_LSB + THR_W;
    localparam int CNT_LSB = PK_LSB + THR_W;
    localparam int RR_LSB  = CNT_LSB + CNT_W;

    localparam logic [63:0] MAG_MAX   = (64'd1 << (SMP_W - 1)) - 1;
    localparam logic [63:0] TS_MAX    = (64'd1 << TS_W) - 1;
    localparam logic [63:0] FLOOR_THR = 1280;
    localparam logic [63:0] RR_LO_MS  = 334;
    localparam logic [63:0] RR_HI_MS  = 1500;
    localparam logic [63:0] BPM_SCALE = 15360000;  // 60000 min->ms, Q8
    localparam int DRAIN_CYC  = 120;               // worst accepted-peak latency plus margin
    localparam int TIMEOUT_NS = 30_000_000;

    typedef struct packed {
        logic             bpm_valid;
        logic [BPM_W-1:0] bpm;
        logic             peak_accepted;
        logic [THR_W-1:0] threshold;
        logic [THR_W-1:0] peak_value;
        logic [CNT_W-1:0] interval_count;
        logic [RR_W-1:0]  last_interval_ms;
    } t_hr_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    wire              s_tready;
    logic [IN_W-1:0]  s_tdata;
    wire              m_tvalid;
    logic             m_tready;
    wire  [OUT_W-1:0] m_tdata;
    wire  [1:0]       m_tuser;
    logic             cfg_we;
    logic [15:0]      cfg_wdata;

    adaptive_peak_heart_rate_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    // beat tracker state
    logic [63:0]     trk_prev_mag;
    bit              trk_rising;
    logic [63:0]     trk_last_pk_t;
    logic [63:0]     trk_prev_pk_t;
    logic [63:0]     trk_pk_mag;
    logic [63:0]     trk_pk_avg;
    logic [63:0]     trk_noise_avg;
    logic [63:0]     trk_thresh;
    logic [RR_W-1:0] trk_rr [RING_N];
    int              trk_wr_pos;
    logic [63:0]     trk_fill;
    logic [63:0]     trk_refr;

    t_hr_result  hr_expected [$];
    logic [63:0] run_ts;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          rcv_hold;
    int          n_items;
    int          n_results;
    int          n_peaks;
    int          n_bpm;
    int          n_cfg;
    int          n_errors;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("adaptive_peak_heart_rate_top verification failed");
        $finish;
    end

    function automatic t_hr_result predict_heart_rate(input logic [SMP_W-1:0] smp,
                                                      input logic [TS_W-1:0] ts);
        t_hr_result  r;
        logic [63:0] mag, now, pk, rr, sum, quo;
        bit          took, time_ok;
        took = 0;
        now  = 64'(ts);
        mag  = 64'(smp);
        if (smp[SMP_W-1])
            mag = (64'd1 << SMP_W) - mag;
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        if (mag > trk_prev_mag) begin
            trk_rising = 1;
        end else if (trk_rising && mag < trk_prev_mag) begin
            pk = trk_prev_mag;
            time_ok = (now >= trk_last_pk_t) && (((now - trk_last_pk_t) / 1000) > trk_refr);
            if (pk * 10 > trk_thresh * 7 && time_ok) begin
                trk_prev_pk_t = trk_last_pk_t;
                trk_last_pk_t = now;
                trk_pk_mag    = pk;
                trk_pk_avg    = (85 * trk_pk_avg + 15 * pk + 50) / 100;
                took          = 1;
                // zero previous peak time means no earlier beat
                if (trk_prev_pk_t != 0 && now >= trk_prev_pk_t) begin
                    rr = (now - trk_prev_pk_t) / 1000;
                    if (rr >= RR_LO_MS && rr <= RR_HI_MS) begin
                        trk_rr[trk_wr_pos] = rr[RR_W-1:0];
                        trk_wr_pos = (trk_wr_pos + 1) % RING_N;
                        if (trk_fill < RING_N)
                            trk_fill++;
                    end
                end
            end else begin
                trk_noise_avg = (92 * trk_noise_avg + 8 * pk + 50) / 100;
            end
            trk_rising = 0;
        end
        trk_thresh = (trk_pk_avg + trk_noise_avg + 1) >> 1;
        if (trk_thresh < FLOOR_THR)
            trk_thresh = FLOOR_THR;
        trk_prev_mag = mag;

        r = '0;
        if (took && trk_fill >= 2) begin
            sum = 0;
            for (int i = 0; i < trk_fill; i++)
                sum += 64'(trk_rr[i]);
            quo = (BPM_SCALE * trk_fill + sum / 2) / sum;
            r.bpm_valid = 1'b1;
            r.bpm = quo[BPM_W-1:0];
        end
        r.peak_accepted  = took;
        r.threshold      = trk_thresh[THR_W-1:0];
        r.peak_value     = trk_pk_mag[THR_W-1:0];
        r.interval_count = trk_fill[CNT_W-1:0];
        r.last_interval_ms = (trk_fill == 0) ? '0 : trk_rr[(trk_wr_pos + RING_N - 1) % RING_N];
        return r;
    endfunction

    function automatic logic [SMP_W-1:0] with_sign(input logic [63:0] mag);
        logic [SMP_W-1:0] v;
        v = mag[SMP_W-1:0];
        return ($urandom_range(1) != 0) ? -v : v;
    endfunction

    // mostly peaks the tracker should take, some noise, a few right at the 0.7 boundary
    function automatic logic [63:0] pick_peak_amp();
        logic [63:0] a;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            a = trk_thresh * 7 / 10 + $urandom_range(1);
        else if (roll < 75)
            a = trk_thresh * $urandom_range(75, 400) / 100;
        else
            a = trk_thresh * $urandom_range(5, 69) / 100;
        if (a > MAG_MAX)
            a = MAG_MAX;
        return a;
    endfunction

    function automatic logic [63:0] pick_period_us();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 64'($urandom_range(300_000, 1_560_000));
        else if (roll < 90)
            return 64'($urandom_range(20_000, 333_999));
        return 64'($urandom_range(1_500_000, 3_000_000));
    endfunction

    function automatic logic [63:0] strong_amp();
        return (trk_thresh * 3 > MAG_MAX) ? MAG_MAX : trk_thresh * 3;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch in %0s at result %0d: expected %0d, got %0d",
                     what, n_results, want, got);
    endtask

    task automatic check_result();
        t_hr_result want, got;
        got.bpm_valid        = m_tuser[0];
        got.peak_accepted    = m_tuser[1];
        got.bpm              = m_tdata[BPM_W-1:0];
        got.threshold        = m_tdata[THR_LSB +: THR_W];
        got.peak_value       = m_tdata[PK_LSB +: THR_W];
        got.interval_count   = m_tdata[CNT_LSB +: CNT_W];
        got.last_interval_ms = m_tdata[RR_LSB +: RR_W];
        n_results++;
        if (hr_expected.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("result %0d arrived with nothing pending", n_results);
        end else begin
            want = hr_expected.pop_front();
            n_peaks += want.peak_accepted;
            n_bpm   += want.bpm_valid;
            if (got.bpm_valid !== want.bpm_valid)
                flag_mismatch("bpm_valid", 64'(want.bpm_valid), 64'(got.bpm_valid));
            if (got.bpm !== want.bpm)
                flag_mismatch("bpm", 64'(want.bpm), 64'(got.bpm));
            if (got.peak_accepted !== want.peak_accepted)
                flag_mismatch("peak_accepted", 64'(want.peak_accepted),
                              64'(got.peak_accepted));
            if (got.threshold !== want.threshold)
                flag_mismatch("threshold", 64'(want.threshold), 64'(got.threshold));
            if (got.peak_value !== want.peak_value)
                flag_mismatch("peak_value", 64'(want.peak_value), 64'(got.peak_value));
            if (got.interval_count !== want.interval_count)
                flag_mismatch("interval_count", 64'(want.interval_count),
                              64'(got.interval_count));
            if (got.last_interval_ms !== want.last_interval_ms)
                flag_mismatch("last_interval_ms", 64'(want.last_interval_ms),
                              64'(got.last_interval_ms));
        end
    endtask

    // output side: one ready decision per clock, long hold-off counted here
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready)
                check_result();
            if (rcv_hold > 0) begin
                m_tready <= 1'b0;
                rcv_hold--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // tvalid stays high across back-to-back transactions; only dropped for idle cycles
    task automatic send_sample(input logic [SMP_W-1:0] smp, input logic [TS_W-1:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, smp};
        do
            @(posedge i_clk);
        while (!s_tready);
        n_items++;
        hr_expected.push_back(predict_heart_rate(smp, ts));
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hr_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_refractory(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (v != 0)
            trk_refr = 64'(v);
        n_cfg++;
        @(posedge i_clk);
    endtask

    // baseline, rise, optional plateau, then the falling sample that decides the peak
    task automatic send_beat(input logic [63:0] amp, input logic [63:0] period_us,
                             input bit go_back);
        logic [63:0] t0, dt, lvl;
        int n_base, n_rise, n_flat, n_all;
        n_base = $urandom_range(1, 3);
        n_rise = $urandom_range(1, 3);
        n_flat = ($urandom_range(99) < 20) ? 1 : 0;
        n_all  = n_base + n_rise + n_flat + 1;
        if (go_back && trk_last_pk_t > 2 * period_us) begin
            t0 = trk_last_pk_t - 2 * period_us;
        end else begin
            t0 = run_ts;
            run_ts = run_ts + period_us;
        end
        dt = period_us / n_all;
        for (int j = 0; j < n_all; j++) begin
            if (j < n_base)
                lvl = 64'($urandom_range(0, 32'(amp / 8)));
            else if (j < n_base + n_rise)
                lvl = amp * (j - n_base + 1) / n_rise;
            else if (j < n_all - 1)
                lvl = amp;
            else
                lvl = amp / $urandom_range(2, 10);
            send_sample(with_sign(lvl),
                        TS_W'((j == n_all - 1) ? t0 + period_us : t0 + dt * (j + 1)));
        end
    endtask

    task automatic random_step();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 84) begin
            send_beat(pick_peak_amp(), pick_period_us(), $urandom_range(99) < 4);
        end else if (roll < 94) begin
            run_ts = run_ts + $urandom_range(1, 30_000);
            send_sample(SMP_W'($urandom), TS_W'(run_ts));
        end else begin
            // same magnitude, arbitrary time: leaves the tracker untouched
            send_sample(with_sign(trk_prev_mag), TS_W'({$urandom, $urandom}));
        end
    endtask

    task automatic test_directed_cases();
        send_sample(24'sd0, 40'd0);
        send_sample(24'sd0, 40'd0);              // equal magnitudes at zero
        send_sample(24'sd20000, 40'd1000);
        send_sample(-24'sd20000, 40'd2000);      // equal magnitude, still rising
        send_sample(24'sd100, 40'd3000);         // peak inside refractory window
        send_sample(24'sd20000, 40'd400000);
        send_sample(-24'sd50, 40'd410000);       // first peak, no earlier beat
        send_sample(-24'sd20000, 40'd1000000);
        send_sample(24'sd0, 40'd1010000);        // 600 ms interval
        send_sample(24'sd20000, 40'd1200000);
        send_sample(24'sd0, 40'd1210000);        // 200 ms < 250 ms refractory
        settle_idle();
        write_refractory(16'd1);
        send_sample(24'sd20000, 40'd1350000);
        send_sample(24'sd0, 40'd1360000);        // 350 ms, second interval, bpm
        send_sample(24'sd20000, 40'd1490000);
        send_sample(24'sd0, 40'd1500000);        // 140 ms, too short
        send_sample(24'sd20000, 40'd3190000);
        send_sample(24'sd0, 40'd3200000);        // 1700 ms, too long
        send_sample(24'sd20000, 40'd1990000);
        send_sample(24'sd0, 40'd2000000);        // time before last peak
        settle_idle();
        write_refractory(16'd0);                 // must be ignored
        send_sample(24'sh7FFFFF, 40'd3600000);
        send_sample(24'sh800000, 40'd3610000);   // saturates to the same magnitude
        send_sample(-24'sd1, 40'd3620000);
        send_sample(24'sh800000, 40'd3630000);
        send_sample(24'sd1, 40'd3640000);
        send_sample(-24'sd1, TS_MAX[TS_W-1:0]);  // equal magnitude at top of time range
        run_ts = 64'd3_700_000;
    endtask

    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                       input int n, input logic [15:0] refr);
        int stop_at;
        settle_idle();
        write_refractory(refr);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        stop_at = n_items + n;
        while (n_items < stop_at)
            random_step();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rcv_hold = 600;
        for (int b = 0; b < 10; b++)
            send_beat(pick_peak_amp(), pick_period_us(), 1'b0);
        settle_idle();
    endtask

    task automatic test_refractory_extremes();
        settle_idle();
        write_refractory(16'hFFFF);
        for (int b = 0; b < 6; b++)
            send_beat(strong_amp(), 64'd800_000, 1'b0);
        send_beat(strong_amp(), 64'd70_000_000, 1'b0);   // clears the 65.5 s window
        settle_idle();
        write_refractory(16'd1);
        for (int b = 0; b < 10; b++)
            send_beat(pick_peak_amp(), pick_period_us(), 1'b0);
    endtask

    // interval edges 333/334 and 1500/1501 ms, ending exactly at the largest timestamp
    task automatic test_interval_bounds();
        settle_idle();
        write_refractory(16'd250);
        run_ts = TS_MAX - 64'd4_669_998;
        send_beat(strong_amp(), 64'd1_000_000, 1'b0);
        send_beat(strong_amp(), 64'd333_999, 1'b0);
        send_beat(strong_amp(), 64'd334_000, 1'b0);
        send_beat(strong_amp(), 64'd1_500_999, 1'b0);
        send_beat(strong_amp(), 64'd1_501_000, 1'b0);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rcv_hold  = 0;
        n_items   = 0;
        n_results = 0;
        n_peaks   = 0;
        n_bpm     = 0;
        n_cfg     = 0;
        n_errors  = 0;
        run_ts    = 0;

        trk_prev_mag  = 0;
        trk_rising    = 0;
        trk_last_pk_t = 0;
        trk_prev_pk_t = 0;
        trk_pk_mag    = 0;
        trk_pk_avg    = 7680;
        trk_noise_avg = 1280;
        trk_thresh    = 7680;
        trk_wr_pos    = 0;
        trk_fill      = 0;
        trk_refr      = 250;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(7, 69, 350, 16'd250);
        test_random_traffic(69, 7, 350, 16'($urandom_range(150, 330)));
        test_output_backpressure();
        test_random_traffic(0, 0, 350, 16'($urandom_range(1, 400)));
        test_refractory_extremes();
        test_interval_bounds();
        settle_idle();

        $display("covered %0d samples and %0d results: %0d accepted peaks, %0d rate reports",
                 n_items, n_results, n_peaks, n_bpm);
        $display("%0d refractory writes incl. 0, 1 and 65535; three idle profiles, one long stall",
                 n_cfg);
        if (n_errors > 10)
            $display("%0d mismatches in total", n_errors);
        if (n_errors == 0)
            $display("adaptive_peak_heart_rate_top verification clean");
        else
            $display("adaptive_peak_heart_rate_top verification failed");
        $finish;
    end

endmodule
